>>> hw/rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher package
// Shared widths, register indexes, quarter-round tables and rotate helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

    // Word and configuration widths.
    localparam int WORD_W = 32;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    // Number of double rounds and the width of the round counter.
    localparam int DOUBLE_ROUNDS = 10;
    localparam int RND_W         = $clog2(DOUBLE_ROUNDS);

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_KEY_01   = 3'd0,
        REG_KEY_23   = 3'd1,
        REG_KEY_45   = 3'd2,
        REG_KEY_67   = 3'd3,
        REG_NONCE_01 = 3'd4,
        REG_NONCE_2  = 3'd5,
        REG_INIT_CTR = 3'd6
    } cfg_reg_t;

    // Operand roles inside one quarter round.
    typedef enum logic [1:0] {
        ROLE_A = 2'd0,
        ROLE_B = 2'd1,
        ROLE_C = 2'd2,
        ROLE_D = 2'd3
    } qr_role_t;

    // The four ChaCha constant words.
    localparam logic [WORD_W-1:0] SIGMA [0:3] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    // State word indexes for the four column and four diagonal quarter rounds.
    localparam logic [3:0] QR_IDX [0:7][0:3] = '{
        '{4'd0, 4'd4, 4'd8,  4'd12},
        '{4'd1, 4'd5, 4'd9,  4'd13},
        '{4'd2, 4'd6, 4'd10, 4'd14},
        '{4'd3, 4'd7, 4'd11, 4'd15},
        '{4'd0, 4'd5, 4'd10, 4'd15},
        '{4'd1, 4'd6, 4'd11, 4'd12},
        '{4'd2, 4'd7, 4'd8,  4'd13},
        '{4'd3, 4'd4, 4'd9,  4'd14}
    };

    // Per micro-op: the word that is updated and the word it is combined with.
    // Even ops add, odd ops XOR and rotate.
    localparam qr_role_t DST_ROLE [0:7] = '{
        ROLE_A, ROLE_D, ROLE_C, ROLE_B, ROLE_A, ROLE_D, ROLE_C, ROLE_B
    };
    localparam qr_role_t SRC_ROLE [0:7] = '{
        ROLE_B, ROLE_A, ROLE_D, ROLE_C, ROLE_B, ROLE_A, ROLE_D, ROLE_C
    };

    // Left rotate by 16, 12, 8 or 7 bits, chosen by the step of the quarter round.
    function automatic logic [WORD_W-1:0] rotl_step(
        input logic [WORD_W-1:0] v,
        input logic [1:0]        sel
    );
        logic [WORD_W-1:0] r;
        case (sel)
            2'd0:    r = {v[15:0], v[31:16]};
            2'd1:    r = {v[19:0], v[31:20]};
            2'd2:    r = {v[23:0], v[31:24]};
            2'd3:    r = {v[24:0], v[31:25]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ccs_in_if.sv
// ----------------------------------------------------------------------------
// Plaintext word channel
// Valid/ready channel carrying one message word and its start and last marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_in_if
    import ccs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              start_message;
    logic              last_word;

    modport source (
        output valid,
        output data_word,
        output start_message,
        output last_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_word,
        input  start_message,
        input  last_word,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/ccs_out_if.sv
// ----------------------------------------------------------------------------
// Ciphertext word channel
// Valid/ready channel carrying one encrypted word and its last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_out_if
    import ccs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] cipher_word;
    logic              last_out;

    modport source (
        output valid,
        output cipher_word,
        output last_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  cipher_word,
        input  last_out,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/ccs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

`default_nettype wire

>>> hw/rtl/chacha20_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher unit
// Encrypts 32-bit message words with the ChaCha20 keystream.
// ----------------------------------------------------------------------------
// Usage:
//   Key, nonce and initial block counter are written through the cfg_* port
//   while the unit is idle. Message words enter on the plain channel, one word
//   per handshake; each leaves on the cipher channel XORed with the keystream
//   word at the same position of its 64-byte block. start_message reloads the
//   block counter from the initial counter register; last_word ends the block.
//   At position zero of a block the keystream block is generated with one
//   shared add/xor/rotate unit over a 16-word working RAM: a load of all
//   16 state words, a read state and an execute state per quarter-round
//   micro-op (8 per quarter round, 8 quarter rounds per double round) and
//   a read and an add per word for the final add, which leaves the
//   keystream block in the same RAM. A word that opens a block returns
//   once the block is generated, any other word without generation; the
//   unit is ready again when the word leaves the output state. The RAM
//   read-to-write turnaround on the dependent micro-op chain sets the
//   generation time.
//   One word is in flight at a time; a finished word waits in the output
//   register while the next word is accepted. Reset clears the position and
//   the block counter, loads the initial counter with 1 and the key and nonce
//   with zero. A stalled receiver holds the result and the unit waits.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_cipher_unit
    import ccs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    ccs_in_if.sink                plain,
    ccs_out_if.source             cipher
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOAD   = 7'b0000010,
        ST_RD     = 7'b0000100,
        ST_EX     = 7'b0001000,
        ST_FIN_RD = 7'b0010000,
        ST_FIN_EX = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    // Configuration registers.
    logic [CFG_W-1:0]  key01_reg, key23_reg, key45_reg, key67_reg, nonce01_reg;
    logic [WORD_W-1:0] nonce2_reg, init_ctr_reg;

    // Control state.
    state_t            state_reg, state_next;
    logic [3:0]        pos_reg, pos_next;
    logic [WORD_W-1:0] bc_reg, bc_next;
    logic [3:0]        idx_reg, idx_next;
    logic [2:0]        op_reg, op_next;
    logic [2:0]        qr_reg, qr_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers.
    logic [WORD_W-1:0] data_reg;
    logic              last_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_last_reg;

    // Datapath signals.
    logic              accept;
    logic              can_load;
    logic              last_micro_op;
    logic [3:0]        pos_eff;
    logic [3:0]        pos_inc;
    logic [WORD_W-1:0] init_word;
    logic [3:0]        dst_addr, src_addr;
    logic [WORD_W-1:0] rdata_a, rdata_b;
    logic [WORD_W-1:0] add_b, sum, arx_result;
    logic              ram_we;
    logic [3:0]        ram_waddr, ram_raddr_a;
    logic [WORD_W-1:0] ram_wdata;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg    <= '0;
            key23_reg    <= '0;
            key45_reg    <= '0;
            key67_reg    <= '0;
            nonce01_reg  <= '0;
            nonce2_reg   <= '0;
            init_ctr_reg <= WORD_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_KEY_01:   key01_reg    <= cfg_data;
                REG_KEY_23:   key23_reg    <= cfg_data;
                REG_KEY_45:   key45_reg    <= cfg_data;
                REG_KEY_67:   key67_reg    <= cfg_data;
                REG_NONCE_01: nonce01_reg  <= cfg_data;
                REG_NONCE_2:  nonce2_reg   <= cfg_data[WORD_W-1:0];
                REG_INIT_CTR: init_ctr_reg <= cfg_data[WORD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Initial block state word at the current index.
    always_comb
    begin
        case (idx_reg)
            4'd0:    init_word = SIGMA[0];
            4'd1:    init_word = SIGMA[1];
            4'd2:    init_word = SIGMA[2];
            4'd3:    init_word = SIGMA[3];
            4'd4:    init_word = key01_reg[31:0];
            4'd5:    init_word = key01_reg[63:32];
            4'd6:    init_word = key23_reg[31:0];
            4'd7:    init_word = key23_reg[63:32];
            4'd8:    init_word = key45_reg[31:0];
            4'd9:    init_word = key45_reg[63:32];
            4'd10:   init_word = key67_reg[31:0];
            4'd11:   init_word = key67_reg[63:32];
            4'd12:   init_word = bc_reg;
            4'd13:   init_word = nonce01_reg[31:0];
            4'd14:   init_word = nonce01_reg[63:32];
            4'd15:   init_word = nonce2_reg;
            default: init_word = '0;
        endcase
    end

    // Operand addresses of the current quarter-round micro-op.
    assign dst_addr = QR_IDX[qr_reg][DST_ROLE[op_reg]];
    assign src_addr = QR_IDX[qr_reg][SRC_ROLE[op_reg]];

    // Shared add/xor/rotate unit; the final add reuses the adder.
    assign add_b      = (state_reg == ST_FIN_EX) ? init_word : rdata_b;
    assign sum        = rdata_a + add_b;
    assign arx_result = op_reg[0] ? rotl_step(rdata_a ^ rdata_b, op_reg[2:1]) : sum;

    // Working word RAM ports. The final add writes the keystream block back
    // in place, and port A then reads the keystream word for the output.
    assign ram_we      = (state_reg == ST_LOAD) || (state_reg == ST_EX)
                      || (state_reg == ST_FIN_EX);
    assign ram_waddr   = ((state_reg == ST_LOAD) || (state_reg == ST_FIN_EX)) ? idx_reg
                                                                               : dst_addr;
    assign ram_wdata   = (state_reg == ST_LOAD)   ? init_word :
                         (state_reg == ST_FIN_EX) ? sum       : arx_result;
    assign ram_raddr_a = (state_reg == ST_IDLE)   ? pos_eff :
                         (state_reg == ST_FIN_RD) ? idx_reg :
                         ((state_reg == ST_FIN_EX) || (state_reg == ST_OUT)) ? pos_reg
                                                                              : dst_addr;

    ccs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (16)
    ) u_work_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (src_addr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Handshake terms.
    assign plain.ready   = (state_reg == ST_IDLE);
    assign accept        = plain.valid && plain.ready;
    assign can_load      = !out_valid_reg || cipher.ready;
    assign pos_eff       = plain.start_message ? 4'd0 : pos_reg;
    assign pos_inc       = pos_reg + 4'd1;
    assign last_micro_op = (op_reg == 3'd7) && (qr_reg == 3'd7)
                        && (rnd_reg == RND_W'(DOUBLE_ROUNDS - 1));

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        bc_next        = bc_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        qr_next        = qr_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg && !cipher.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next = pos_eff;
                    if (plain.start_message)
                    begin
                        bc_next = init_ctr_reg;
                    end
                    idx_next   = '0;
                    state_next = (pos_eff == 4'd0) ? ST_LOAD : ST_OUT;
                end
            end
            ST_LOAD:
            begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg == 4'd15)
                begin
                    op_next    = '0;
                    qr_next    = '0;
                    rnd_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EX;
            end
            ST_EX:
            begin
                op_next = op_reg + 3'd1;
                if (op_reg == 3'd7)
                begin
                    qr_next = qr_reg + 3'd1;
                    if (qr_reg == 3'd7)
                    begin
                        rnd_next = last_micro_op ? '0 : rnd_reg + RND_W'(1);
                    end
                end
                if (last_micro_op)
                begin
                    idx_next   = '0;
                    state_next = ST_FIN_RD;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_FIN_RD:
            begin
                state_next = ST_FIN_EX;
            end
            ST_FIN_EX:
            begin
                idx_next   = idx_reg + 4'd1;
                state_next = (idx_reg == 4'd15) ? ST_OUT : ST_FIN_RD;
            end
            ST_OUT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    // Counter advances when the block wraps or a last word
                    // ends it early, but not when a last word fills it.
                    if (last_reg)
                    begin
                        pos_next = '0;
                        if (pos_inc != 4'd0)
                        begin
                            bc_next = bc_reg + WORD_W'(1);
                        end
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        if (pos_inc == 4'd0)
                        begin
                            bc_next = bc_reg + WORD_W'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            bc_reg        <= '0;
            idx_reg       <= '0;
            op_reg        <= '0;
            qr_reg        <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bc_reg        <= bc_next;
            idx_reg       <= idx_next;
            op_reg        <= op_next;
            qr_reg        <= qr_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word capture and output register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= plain.data_word;
            last_reg <= plain.last_word;
        end
        if ((state_reg == ST_OUT) && can_load)
        begin
            out_word_reg <= data_reg ^ rdata_a;
            out_last_reg <= last_reg;
        end
    end

    assign cipher.valid       = out_valid_reg;
    assign cipher.cipher_word = out_word_reg;
    assign cipher.last_out    = out_last_reg;

    // A start mark reloads the counter and restarts the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && plain.start_message |=> (bc_reg == $past(init_ctr_reg)) && (pos_reg == 4'd0))
    else $error("start mark did not reload the block counter");

    // A new result appears only out of the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
    else $error("result raised outside the output state");

    // The final add begins only after the last micro-op of the last round.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN_RD) && $past(state_reg == ST_EX) |-> $past(last_micro_op))
    else $error("final add entered before all rounds finished");

    // A word at a block start always generates a new keystream block.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (pos_eff == 4'd0) |=> (state_reg == ST_LOAD))
    else $error("block start did not generate keystream");

    // The round counter stays within the configured round count.
    assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= RND_W'(DOUBLE_ROUNDS - 1))
    else $error("round counter out of range");

endmodule

`default_nettype wire
